// ----- rtl/dpfsc_pkg.sv -----
// Shared types, constants and saturation helpers for the dual speed regulator
package dpfsc_pkg;

  // data path widths, all values signed Q16.16
  localparam int DW     = 32;
  localparam int FRAC_W = 16;
  localparam int ERR_W  = DW + 1;

  // loop rate and friction offset of the drive
  localparam int                     LOOP_RATE       = 1000;
  localparam logic signed [DW-1:0]   FRICTION_OFFSET = 32'sd0;

  // target acceleration: 33 bit difference times the loop rate
  localparam int                     RATE_W    = 18;
  localparam logic signed [RATE_W-1:0] RATE_S  = RATE_W'(LOOP_RATE);
  localparam int                     ACC_RAW_W = ERR_W + RATE_W;

  // gain products
  localparam int SPD_W  = 2 * DW;
  localparam int PROD_W = DW + ERR_W;

  // integrator increment: floor(product / 2^16 / LOOP_RATE) by reciprocal
  localparam int DIV_IN_W    = PROD_W - 2 - FRAC_W;
  localparam int RECIP_W     = DIV_IN_W + 1;
  localparam int RECIP_SHIFT = DIV_IN_W + $clog2(LOOP_RATE);
  localparam logic [95:0] RECIP_FULL =
    (((96'd1 << RECIP_SHIFT) - 96'd1) / 96'(LOOP_RATE)) + 96'd1;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int HALF_W = 24;
  localparam int PP_W   = 2 * HALF_W;
  localparam int SUM_W  = DIV_IN_W + RECIP_W;
  localparam int QUOT_W = 41;
  localparam int INC_W  = QUOT_W + 1;

  // feedforward plus proportional sum and final drive sum
  localparam int FF_W     = 50;
  localparam int SAT_IN_W = 51;

  // integrator decay by 99/100: i - ceil(i/100), ceil by reciprocal
  localparam int DECAY_DIV   = 100;
  localparam int DEC_SHIFT   = DW + $clog2(DECAY_DIV);
  localparam int DEC_RECIP_W = DW + 1;
  localparam logic [95:0] DEC_FULL =
    (((96'd1 << DEC_SHIFT) - 96'd1) / 96'(DECAY_DIV)) + 96'd1;
  localparam logic [DEC_RECIP_W-1:0] DEC_RECIP = DEC_FULL[DEC_RECIP_W-1:0];

  // configuration register index
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_DECAY = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_ACCEL = 3'd0,
    REG_MOVE_SPEED = 3'd1,
    REG_MOVE_PROP  = 3'd2,
    REG_MOVE_INTEG = 3'd3,
    REG_TURN_ACCEL = 3'd4,
    REG_TURN_SPEED = 3'd5,
    REG_TURN_PROP  = 3'd6,
    REG_TURN_INTEG = 3'd7
  } cfg_reg_t;

  // gain set of one channel
  typedef struct packed {
    logic signed [DW-1:0] accel;
    logic signed [DW-1:0] speed;
    logic signed [DW-1:0] prop;
    logic signed [DW-1:0] integ;
  } chan_gain_t;

  // load enables of the channel pipeline stages
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } stage_en_t;

  // true when the value fits in 32 signed bits
  function automatic logic fits32(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-DW:0] top_bits;
    top_bits = v[SAT_IN_W-1:DW-1];
    return (top_bits == '0) || (top_bits == '1);
  endfunction

  // clip to the 32 bit signed range
  function automatic logic signed [DW-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic signed [DW-1:0] res;
    if (fits32(v)) begin
      res = v[DW-1:0];
    end else if (v[SAT_IN_W-1]) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = {1'b0, {(DW-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ----- rtl/dpfsc_if.sv -----
// Channel interfaces of the dual speed regulator: input, result and configuration
interface dpfsc_in_if
  import dpfsc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic signed [DW-1:0] target_move;
  logic signed [DW-1:0] measured_move;
  logic signed [DW-1:0] target_turn;
  logic signed [DW-1:0] measured_turn;

  modport source (
    output valid, func, target_move, measured_move, target_turn, measured_turn,
    input  ready
  );
  modport sink (
    input  valid, func, target_move, measured_move, target_turn, measured_turn,
    output ready
  );
endinterface

interface dpfsc_out_if
  import dpfsc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] voltage_sum;
  logic signed [DW-1:0] voltage_diff;
  logic                 saturated;

  modport source (
    output valid, voltage_sum, voltage_diff, saturated,
    input  ready
  );
  modport sink (
    input  valid, voltage_sum, voltage_diff, saturated,
    output ready
  );
endinterface

interface dpfsc_cfg_if
  import dpfsc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DW-1:0]        data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/dual_pi_feedforward_speed_control.sv -----
// Top level of the dual PI speed regulator with feedforward for a differential drive
//
//   channel   direction  handshake          payload
//   cfg_ch    in         valid / ready      index, data
//   in_ch     in         valid / ready      func, target_move, measured_move,
//                                           target_turn, measured_turn
//   out_ch    out        valid / ready      voltage_sum, voltage_diff, saturated
//
// One word is taken per cycle unless a stalled result has filled every stage; the
// accepting edge loads the first of four channel stages (a to d), which feed the result
// register where the integrators close the loop.
// Reset (rst_n low, synchronous) clears gains, integrators, last targets,
// held drives and every valid bit. A stalled result only holds the stages that
// are full; empty stages keep taking words. cfg_ch is always ready.
module dual_pi_feedforward_speed_control
  import dpfsc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  dpfsc_cfg_if.sink    cfg_ch,
  dpfsc_in_if.sink     in_ch,
  dpfsc_out_if.source  out_ch
);

  chan_gain_t move_gain_r, turn_gain_r;

  logic a_valid_r, b_valid_r, c_valid_r, d_valid_r, out_valid_r;
  func_t a_func_r, b_func_r, c_func_r, d_func_r;
  logic take_a, take_b, take_c, take_d, take_e;
  logic in_take, step_take, e_fire;
  stage_en_t en;

  logic signed [INC_W-1:0] move_inc, turn_inc;
  logic signed [FF_W-1:0]  move_ff, turn_ff;

  logic signed [DW-1:0] move_integ_r, turn_integ_r, held_sum_r, held_diff_r;
  logic                 sat_r;
  logic signed [DW-1:0] move_integ_nxt, turn_integ_nxt, held_sum_nxt, held_diff_nxt;
  logic                 sat_nxt;

  logic signed [INC_W:0]      m_isum, t_isum;
  logic signed [DW-1:0]       m_integ_new, t_integ_new, m_drive, t_drive;
  logic signed [SAT_IN_W-1:0] m_total, t_total;
  logic                       m_iclip, t_iclip, m_dclip, t_dclip;

  logic [DW-1:0]                 dec_mag, dec_q, dec_ceil;
  logic [DW+DEC_RECIP_W-1:0]     dec_prod;
  logic signed [DW-1:0]          turn_decayed;

  // gain register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_gain_r <= '0;
      turn_gain_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MOVE_ACCEL: move_gain_r.accel <= cfg_ch.data;
        REG_MOVE_SPEED: move_gain_r.speed <= cfg_ch.data;
        REG_MOVE_PROP:  move_gain_r.prop  <= cfg_ch.data;
        REG_MOVE_INTEG: move_gain_r.integ <= cfg_ch.data;
        REG_TURN_ACCEL: turn_gain_r.accel <= cfg_ch.data;
        REG_TURN_SPEED: turn_gain_r.speed <= cfg_ch.data;
        REG_TURN_PROP:  turn_gain_r.prop  <= cfg_ch.data;
        REG_TURN_INTEG: turn_gain_r.integ <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // stage flow control, each stage loads when empty or draining
  assign take_e    = !out_valid_r || out_ch.ready;
  assign take_d    = !d_valid_r || take_e;
  assign take_c    = !c_valid_r || take_d;
  assign take_b    = !b_valid_r || take_c;
  assign take_a    = !a_valid_r || take_b;
  assign in_ch.ready = take_a;
  assign in_take   = in_ch.valid && take_a;
  assign step_take = in_take && (func_t'(in_ch.func) == FUNC_STEP);
  assign e_fire    = d_valid_r && take_e;
  assign en        = '{a: take_a, b: take_b, c: take_c, d: take_d};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take_a) a_valid_r   <= in_ch.valid;
      if (take_b) b_valid_r   <= a_valid_r;
      if (take_c) c_valid_r   <= b_valid_r;
      if (take_d) d_valid_r   <= c_valid_r;
      if (take_e) out_valid_r <= d_valid_r;
    end
  end

  // function code follows its word down the stages
  always_ff @(posedge clk) begin
    if (take_a) a_func_r <= func_t'(in_ch.func);
    if (take_b) b_func_r <= a_func_r;
    if (take_c) c_func_r <= b_func_r;
    if (take_d) d_func_r <= c_func_r;
  end

  // translation and rotation channel pipelines
  dpfsc_chan u_move (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .step_take (step_take),
    .target    (in_ch.target_move),
    .measured  (in_ch.measured_move),
    .offset    (FRICTION_OFFSET),
    .gain      (move_gain_r),
    .inc       (move_inc),
    .ff        (move_ff)
  );

  dpfsc_chan u_turn (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .step_take (step_take),
    .target    (in_ch.target_turn),
    .measured  (in_ch.measured_turn),
    .offset    ('0),
    .gain      (turn_gain_r),
    .inc       (turn_inc),
    .ff        (turn_ff)
  );

  // integrator update and drive saturation
  assign m_isum      = (INC_W+1)'(move_inc) + (INC_W+1)'(move_integ_r);
  assign t_isum      = (INC_W+1)'(turn_inc) + (INC_W+1)'(turn_integ_r);
  assign m_integ_new = sat32(SAT_IN_W'(m_isum));
  assign t_integ_new = sat32(SAT_IN_W'(t_isum));
  assign m_iclip     = !fits32(SAT_IN_W'(m_isum));
  assign t_iclip     = !fits32(SAT_IN_W'(t_isum));
  assign m_total     = SAT_IN_W'(move_ff) + SAT_IN_W'(m_integ_new);
  assign t_total     = SAT_IN_W'(turn_ff) + SAT_IN_W'(t_integ_new);
  assign m_drive     = sat32(m_total);
  assign t_drive     = sat32(t_total);
  assign m_dclip     = !fits32(m_total);
  assign t_dclip     = !fits32(t_total);

  // rotation integrator decay: i - ceil(i / 100)
  assign dec_mag  = turn_integ_r[DW-1] ? (~turn_integ_r + 1'b1)
                                       : (turn_integ_r + DW'(DECAY_DIV - 1));
  assign dec_prod = (DW+DEC_RECIP_W)'(dec_mag) * (DW+DEC_RECIP_W)'(DEC_RECIP);
  assign dec_q    = DW'(dec_prod >> DEC_SHIFT);
  assign dec_ceil = turn_integ_r[DW-1] ? (~dec_q + 1'b1) : dec_q;
  assign turn_decayed = turn_integ_r - dec_ceil;

  // next state per function code
  always_comb begin
    move_integ_nxt = move_integ_r;
    turn_integ_nxt = turn_integ_r;
    held_sum_nxt   = held_sum_r;
    held_diff_nxt  = held_diff_r;
    sat_nxt        = 1'b0;
    case (d_func_r)
      FUNC_STEP: begin
        move_integ_nxt = m_integ_new;
        turn_integ_nxt = t_integ_new;
        held_sum_nxt   = m_drive;
        held_diff_nxt  = t_drive;
        sat_nxt        = m_iclip || m_dclip || t_iclip || t_dclip;
      end
      FUNC_CLEAR: begin
        move_integ_nxt = '0;
        turn_integ_nxt = '0;
      end
      FUNC_DECAY: begin
        turn_integ_nxt = turn_decayed;
      end
      default: ;
    endcase
  end

  // integrators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_integ_r <= '0;
      turn_integ_r <= '0;
      held_sum_r   <= '0;
      held_diff_r  <= '0;
      sat_r        <= 1'b0;
    end else if (e_fire) begin
      move_integ_r <= move_integ_nxt;
      turn_integ_r <= turn_integ_nxt;
      held_sum_r   <= held_sum_nxt;
      held_diff_r  <= held_diff_nxt;
      sat_r        <= sat_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.voltage_sum  = held_sum_r;
  assign out_ch.voltage_diff = held_diff_r;
  assign out_ch.saturated    = sat_r;

  // only a control step can report clipping
  a_nostep_sat: assert property (@(posedge clk) disable iff (!rst_n)
    e_fire && (d_func_r != FUNC_STEP) |=> !sat_r)
    else $error("clip flag set by a non-step word");

  // drives change only on a control step
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(e_fire && (d_func_r == FUNC_STEP)) |=> $stable(held_sum_r) && $stable(held_diff_r))
    else $error("held drive changed without a control step");

  // clear empties both integrators
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    e_fire && (d_func_r == FUNC_CLEAR) |=> (move_integ_r == '0) && (turn_integ_r == '0))
    else $error("integrators not cleared");

  // decay leaves the translation integrator untouched
  a_decay_move: assert property (@(posedge clk) disable iff (!rst_n)
    e_fire && (d_func_r == FUNC_DECAY) |=> $stable(move_integ_r))
    else $error("decay touched the translation integrator");

  // the input stalls only when every stage holds a word
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> a_valid_r && b_valid_r && c_valid_r && d_valid_r && out_valid_r)
    else $error("input stalled with an empty stage");

endmodule

// ----- rtl/dpfsc_chan.sv -----
// One regulator channel: pipeline from targets to integrator step and drive sum; holds the last step target
module dpfsc_chan
  import dpfsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  stage_en_t              en,
  input  logic                   step_take,
  input  logic signed [DW-1:0]   target,
  input  logic signed [DW-1:0]   measured,
  input  logic signed [DW-1:0]   offset,
  input  chan_gain_t             gain,
  output logic signed [INC_W-1:0] inc,
  output logic signed [FF_W-1:0]  ff
);

  localparam int YH_W = DIV_IN_W - HALF_W;
  localparam int MH_W = RECIP_W - HALF_W;
  localparam logic [MH_W-1:0]   M_HI = RECIP[RECIP_W-1:HALF_W];
  localparam logic [HALF_W-1:0] M_LO = RECIP[HALF_W-1:0];

  logic signed [DW-1:0] g_acc, g_spd, g_prp, g_int;

  logic signed [DW-1:0]    last_target_r;
  logic signed [DW-1:0]    a_target_r;
  logic signed [ERR_W-1:0] a_err_r, a_dlt_r;

  logic signed [ACC_RAW_W-1:0] b_acc_raw_r;
  logic signed [SPD_W-1:0]     b_speed_r;
  logic signed [PROD_W-1:0]    b_prop_r, b_integ_r;

  logic signed [DW-1:0]     accel_c;
  logic [PROD_W-1:0]        int_mag;
  logic [DIV_IN_W-1:0]      div_in;
  logic [YH_W-1:0]          y_hi;
  logic [HALF_W-1:0]        y_lo;

  logic signed [SPD_W-1:0]          c_accel_p_r;
  logic signed [SPD_W-FRAC_W-1:0]   c_speed_t_r;
  logic signed [PROD_W-FRAC_W-1:0]  c_prop_t_r;
  logic                             c_neg_r;
  logic [PP_W-1:0]                  c_pp_hh_r, c_pp_hl_r, c_pp_lh_r, c_pp_ll_r;

  logic signed [SPD_W-FRAC_W-1:0] accel_t;
  logic [SUM_W-1:0]               pp_sum;
  logic [QUOT_W-1:0]              quot;

  logic signed [INC_W-1:0] d_inc_r;
  logic signed [FF_W-1:0]  d_ff_r;

  assign g_acc = gain.accel;
  assign g_spd = gain.speed;
  assign g_prp = gain.prop;
  assign g_int = gain.integ;

  // previous target of the last control step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_target_r <= '0;
    end else if (step_take) begin
      last_target_r <= target;
    end
  end

  // stage a: speed error and target step
  always_ff @(posedge clk) begin
    if (en.a) begin
      a_target_r <= target;
      a_err_r    <= ERR_W'(target) - ERR_W'(measured);
      a_dlt_r    <= ERR_W'(target) - ERR_W'(last_target_r);
    end
  end

  // stage b: raw acceleration and gain products
  always_ff @(posedge clk) begin
    if (en.b) begin
      b_acc_raw_r <= ACC_RAW_W'(a_dlt_r) * ACC_RAW_W'(RATE_S);
      b_speed_r   <= SPD_W'(g_spd) * SPD_W'(a_target_r);
      b_prop_r    <= PROD_W'(g_prp) * PROD_W'(a_err_r);
      b_integ_r   <= PROD_W'(g_int) * PROD_W'(a_err_r);
    end
  end

  // clipped acceleration and magnitude of the integral product
  assign accel_c = sat32(SAT_IN_W'(b_acc_raw_r));
  assign int_mag = b_integ_r[PROD_W-1] ? ~b_integ_r : b_integ_r;
  assign div_in  = int_mag[PROD_W-3:FRAC_W];
  assign y_hi    = div_in[DIV_IN_W-1:HALF_W];
  assign y_lo    = div_in[HALF_W-1:0];

  // stage c: acceleration product, floored terms, reciprocal partial products
  always_ff @(posedge clk) begin
    if (en.c) begin
      c_accel_p_r <= SPD_W'(accel_c) * SPD_W'(g_acc);
      c_speed_t_r <= b_speed_r[SPD_W-1:FRAC_W];
      c_prop_t_r  <= b_prop_r[PROD_W-1:FRAC_W];
      c_neg_r     <= b_integ_r[PROD_W-1];
      c_pp_hh_r   <= PP_W'(y_hi) * PP_W'(M_HI);
      c_pp_hl_r   <= PP_W'(y_hi) * PP_W'(M_LO);
      c_pp_lh_r   <= PP_W'(y_lo) * PP_W'(M_HI);
      c_pp_ll_r   <= PP_W'(y_lo) * PP_W'(M_LO);
    end
  end

  // quotient from the partial products
  assign pp_sum = (SUM_W'(c_pp_hh_r) << (2 * HALF_W))
                + (SUM_W'(c_pp_hl_r) << HALF_W)
                + (SUM_W'(c_pp_lh_r) << HALF_W)
                + SUM_W'(c_pp_ll_r);
  assign quot    = QUOT_W'(pp_sum >> RECIP_SHIFT);
  assign accel_t = c_accel_p_r[SPD_W-1:FRAC_W];

  // stage d: signed integrator step and drive sum without the integral
  always_ff @(posedge clk) begin
    if (en.d) begin
      d_inc_r <= c_neg_r ? ~{1'b0, quot} : {1'b0, quot};
      d_ff_r  <= FF_W'(accel_t) + FF_W'(c_speed_t_r) + FF_W'(c_prop_t_r) + FF_W'(offset);
    end
  end

  assign inc = d_inc_r;
  assign ff  = d_ff_r;

endmodule

// ----- bench/dual_pi_feedforward_speed_control_tb.sv -----
// Self-checking testbench for the dual PI speed regulator with feedforward
`timescale 1ns / 1ps

module dual_pi_feedforward_speed_control_tb;
  import dpfsc_pkg::*;

  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 20;
  localparam int         MAX_REPORTS    = 10;
  localparam int         HOLD_CYCLES    = 150;
  localparam int         PHASES         = 8;
  localparam int         PHASE_WORDS    = 88;
  localparam int         DECAY_KEEP     = DECAY_DIV - 1;

  localparam logic signed [DW-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] S32_MIN = 32'sh80000000;
  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;

  // one word on the input channel
  typedef struct {
    logic [1:0]           func;
    logic signed [DW-1:0] target_move;
    logic signed [DW-1:0] measured_move;
    logic signed [DW-1:0] target_turn;
    logic signed [DW-1:0] measured_turn;
  } cmd_word_t;

  // one word on the result channel
  typedef struct {
    logic signed [DW-1:0] voltage_sum;
    logic signed [DW-1:0] voltage_diff;
    logic                 saturated;
  } drive_word_t;

  logic clk = 1'b0;
  logic rst_n;

  dpfsc_cfg_if cfg_ch ();
  dpfsc_in_if  in_ch ();
  dpfsc_out_if out_ch ();

  dual_pi_feedforward_speed_control dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  // regulator state as the bench sees it
  chan_gain_t  move_gain;
  chan_gain_t  turn_gain;
  longint      move_integ;
  longint      turn_integ;
  longint      prev_target_move;
  longint      prev_target_turn;
  longint      held_sum;
  longint      held_diff;
  drive_word_t drive_fifo[$];

  // sender and receiver control
  bit in_live     = 1'b0;
  bit no_gaps     = 1'b0;
  int burst_left  = 0;
  int hold_left   = 0;

  // trajectory of the random phases
  logic signed [DW-1:0] traj_move = '0;
  logic signed [DW-1:0] traj_turn = '0;

  // run statistics
  int mismatches      = 0;
  int results_checked = 0;
  int clipped_results = 0;
  int steps_sent      = 0;
  int clears_sent     = 0;
  int decays_sent     = 0;
  int unused_sent     = 0;
  int gain_sets       = 0;

  // clip to 32 bit signed, flag when clipped
  function automatic longint clip32(input longint v, inout bit hit);
    if (v > LIM_HI) begin
      hit = 1'b1;
      return LIM_HI;
    end
    if (v < LIM_LO) begin
      hit = 1'b1;
      return LIM_LO;
    end
    return v;
  endfunction

  // division rounded toward minus infinity, den positive
  function automatic longint div_floor(input longint num, input longint den);
    longint q;
    q = num / den;
    if (num % den != 0 && num < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // one PI plus feedforward channel, updates its integrator and last target
  function automatic longint run_loop(input longint tgt, input longint meas,
                                      input longint offset, input chan_gain_t g,
                                      inout longint last, inout longint integ,
                                      inout bit hit);
    longint err;
    longint step_inc;
    longint accel;
    longint total;
    bit     silent;
    silent   = 1'b0;
    err      = tgt - meas;
    step_inc = div_floor((longint'(g.integ) * err) >>> FRAC_W, LOOP_RATE);
    // acceleration clip is not reported
    accel    = clip32((tgt - last) * LOOP_RATE, silent);
    integ    = clip32(integ + step_inc, hit);
    total    = ((longint'(g.accel) * accel) >>> FRAC_W)
             + ((longint'(g.speed) * tgt) >>> FRAC_W)
             + ((longint'(g.prop) * err) >>> FRAC_W)
             + integ + offset;
    last     = tgt;
    return clip32(total, hit);
  endfunction

  // expected result of one accepted word
  function automatic drive_word_t predict_drives(input cmd_word_t w);
    drive_word_t d;
    bit          hit;
    hit = 1'b0;
    case (w.func)
      FUNC_STEP: begin
        held_sum  = run_loop(longint'(w.target_move), longint'(w.measured_move),
                             longint'(FRICTION_OFFSET), move_gain,
                             prev_target_move, move_integ, hit);
        held_diff = run_loop(longint'(w.target_turn), longint'(w.measured_turn),
                             0, turn_gain, prev_target_turn, turn_integ, hit);
      end
      FUNC_CLEAR: begin
        move_integ = 0;
        turn_integ = 0;
      end
      FUNC_DECAY: begin
        turn_integ = div_floor(turn_integ * DECAY_KEEP, DECAY_DIV);
      end
      default: begin
      end
    endcase
    d.voltage_sum  = held_sum[DW-1:0];
    d.voltage_diff = held_diff[DW-1:0];
    d.saturated    = hit;
    return d;
  endfunction

  function automatic cmd_word_t make_cmd(input logic [1:0] f, input logic [DW-1:0] tm,
                                         input logic [DW-1:0] mm, input logic [DW-1:0] tt,
                                         input logic [DW-1:0] mt);
    cmd_word_t w;
    w.func          = f;
    w.target_move   = tm;
    w.measured_move = mm;
    w.target_turn   = tt;
    w.measured_turn = mt;
    return w;
  endfunction

  function automatic chan_gain_t gain_set(input logic [DW-1:0] a, input logic [DW-1:0] s,
                                          input logic [DW-1:0] p, input logic [DW-1:0] i);
    chan_gain_t g;
    g.accel = a;
    g.speed = s;
    g.prop  = p;
    g.integ = i;
    return g;
  endfunction

  function automatic logic signed [DW-1:0] extreme_value();
    logic signed [DW-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = 32'sd1;
      2:       v = -32'sd1;
      3:       v = S32_MAX;
      default: v = S32_MIN;
    endcase
    return v;
  endfunction

  // full range or corner value
  function automatic logic signed [DW-1:0] wild_value();
    logic signed [DW-1:0] v;
    if ($urandom_range(0, 3) == 0) begin
      v = extreme_value();
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // gain of random magnitude, mostly moderate
  function automatic logic signed [DW-1:0] random_gain();
    logic signed [DW-1:0] g;
    g = $urandom;
    if ($urandom_range(0, 7) != 0) begin
      g = g >>> $urandom_range(6, 24);
    end
    return g;
  endfunction

  function automatic int signed_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly smooth trajectory steps, some commands and noise
  function automatic cmd_word_t next_random_cmd();
    cmd_word_t w;
    int        pick;
    int        jump;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      w = make_cmd(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 12) begin
      w = make_cmd(FUNC_DECAY, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 15) begin
      w = make_cmd(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
    end else if (pick < 22) begin
      w = make_cmd(FUNC_STEP, wild_value(), wild_value(), wild_value(), wild_value());
    end else begin
      jump = ($urandom_range(0, 15) == 0) ? 32'h0040_0000 : 32'h0000_4000;
      if ($urandom_range(0, 63) == 0) begin
        traj_move = '0;
        traj_turn = '0;
      end
      traj_move = traj_move + signed_span(jump);
      traj_turn = traj_turn + signed_span(jump);
      w = make_cmd(FUNC_STEP, traj_move, traj_move + signed_span(32'h2000),
                   traj_turn, traj_turn + signed_span(32'h2000));
    end
    return w;
  endfunction

  // stop offering words and wait until every result is back
  task automatic settle();
    if (in_live) begin
      in_ch.valid <= 1'b0;
      in_live = 1'b0;
    end
    do @(posedge clk); while (drive_fifo.size() != 0);
  endtask

  // offer one word in bursts with random gaps, record its expected result
  task automatic send_cmd(input cmd_word_t w);
    int gap;
    if (burst_left == 0) begin
      if (no_gaps || $urandom_range(0, 3) == 0) begin
        gap = 0;
      end else begin
        gap = $urandom_range(1, 8);
      end
      if (gap > 0 && in_live) begin
        in_ch.valid <= 1'b0;
        in_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.func          <= w.func;
    in_ch.target_move   <= w.target_move;
    in_ch.measured_move <= w.measured_move;
    in_ch.target_turn   <= w.target_turn;
    in_ch.measured_turn <= w.measured_turn;
    in_live = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    drive_fifo.push_back(predict_drives(w));
    case (w.func)
      FUNC_STEP:  steps_sent++;
      FUNC_CLEAR: clears_sent++;
      FUNC_DECAY: decays_sent++;
      default:    unused_sent++;
    endcase
  endtask

  task automatic write_gain(input cfg_reg_t idx, input logic [DW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_MOVE_ACCEL: move_gain.accel = val;
      REG_MOVE_SPEED: move_gain.speed = val;
      REG_MOVE_PROP:  move_gain.prop  = val;
      REG_MOVE_INTEG: move_gain.integ = val;
      REG_TURN_ACCEL: turn_gain.accel = val;
      REG_TURN_SPEED: turn_gain.speed = val;
      REG_TURN_PROP:  turn_gain.prop  = val;
      default:        turn_gain.integ = val;
    endcase
  endtask

  // write all eight gains while the block is idle
  task automatic load_gains(input chan_gain_t mv, input chan_gain_t tn);
    settle();
    write_gain(REG_MOVE_ACCEL, mv.accel);
    write_gain(REG_MOVE_SPEED, mv.speed);
    write_gain(REG_MOVE_PROP,  mv.prop);
    write_gain(REG_MOVE_INTEG, mv.integ);
    write_gain(REG_TURN_ACCEL, tn.accel);
    write_gain(REG_TURN_SPEED, tn.speed);
    write_gain(REG_TURN_PROP,  tn.prop);
    write_gain(REG_TURN_INTEG, tn.integ);
    cfg_ch.valid <= 1'b0;
    gain_sets++;
  endtask

  // gains at reset are zero, so every drive stays zero
  task automatic test_reset_state();
    send_cmd(make_cmd(FUNC_STEP, S32_MAX, S32_MIN, S32_MIN, S32_MAX));
    send_cmd(make_cmd(FUNC_DECAY, S32_MIN, S32_MAX, S32_MAX, S32_MIN));
    send_cmd(make_cmd(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom));
  endtask

  // corner gains and fields, every command, clipping and decay of both signs
  task automatic test_directed_cases();
    load_gains(gain_set(S32_MAX, S32_MAX, S32_MAX, S32_MAX),
               gain_set(S32_MAX, S32_MAX, S32_MAX, S32_MAX));
    send_cmd(make_cmd(FUNC_STEP, S32_MAX, S32_MIN, S32_MIN, S32_MAX));
    send_cmd(make_cmd(FUNC_STEP, S32_MIN, S32_MAX, S32_MAX, S32_MIN));
    send_cmd(make_cmd(FUNC_DECAY, '0, '0, '0, '0));
    send_cmd(make_cmd(FUNC_STEP, '0, S32_MAX, '0, S32_MAX));
    send_cmd(make_cmd(FUNC_DECAY, '0, '0, '0, '0));
    send_cmd(make_cmd(FUNC_CLEAR, S32_MAX, S32_MAX, S32_MAX, S32_MAX));
    send_cmd(make_cmd(FUNC_UNUSED, S32_MIN, S32_MIN, S32_MIN, S32_MIN));

    load_gains(gain_set(S32_MIN, S32_MIN, S32_MIN, S32_MIN),
               gain_set(S32_MIN, S32_MIN, S32_MIN, S32_MIN));
    send_cmd(make_cmd(FUNC_STEP, 32'sd1, -32'sd1, -32'sd1, 32'sd1));
    send_cmd(make_cmd(FUNC_STEP, S32_MIN, S32_MIN, S32_MAX, S32_MAX));
    send_cmd(make_cmd(FUNC_DECAY, '0, '0, '0, '0));

    // moderate gains, small ramp with the turn integrator going negative
    load_gains(gain_set(32'sh0000028f, 32'sh00018000, 32'sh00020000, 32'sh012c0000),
               gain_set(32'sh00000083, 32'sh0000c000, 32'shfffec000, 32'sh00320000));
    send_cmd(make_cmd(FUNC_STEP, 32'sh00008000, '0, 32'sh00004000, '0));
    send_cmd(make_cmd(FUNC_STEP, 32'sh00010000, 32'sh00006000, 32'shffff0000,
                      32'sh00002000));
    send_cmd(make_cmd(FUNC_STEP, 32'sh00018000, 32'sh0000f000, 32'shfffe0000,
                      32'shffff8000));
    send_cmd(make_cmd(FUNC_STEP, 32'sh00018000, 32'sh00017000, 32'shfffe0000,
                      32'sh00010000));
    send_cmd(make_cmd(FUNC_DECAY, '0, '0, '0, '0));
    send_cmd(make_cmd(FUNC_DECAY, '0, '0, '0, '0));
    send_cmd(make_cmd(FUNC_CLEAR, '0, '0, '0, '0));
    send_cmd(make_cmd(FUNC_STEP, '0, '0, '0, '0));
  endtask

  // receiver holds off while words keep coming, so the input has to stall
  task automatic test_stalled_result();
    settle();
    hold_left = HOLD_CYCLES;
    no_gaps   = 1'b1;
    repeat (30) send_cmd(next_random_cmd());
    no_gaps   = 1'b0;
    settle();
  endtask

  // random trajectories under several gain settings
  task automatic test_random_trajectories();
    chan_gain_t mv;
    chan_gain_t tn;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          mv = gain_set(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
          tn = mv;
        end
        1: begin
          mv = gain_set(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
          tn = mv;
        end
        2: begin
          mv = gain_set(extreme_value(), extreme_value(), extreme_value(), extreme_value());
          tn = gain_set(extreme_value(), extreme_value(), extreme_value(), extreme_value());
        end
        default: begin
          mv = gain_set(random_gain(), random_gain(), random_gain(), random_gain());
          tn = gain_set(random_gain(), random_gain(), random_gain(), random_gain());
        end
      endcase
      load_gains(mv, tn);
      repeat (PHASE_WORDS) send_cmd(next_random_cmd());
    end
  endtask

  // result checker and receiver stall pattern
  initial begin : result_sink
    drive_word_t want;
    int          cyc;
    out_ch.ready = 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (drive_fifo.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: unexpected word sum=%h diff=%h sat=%b", $realtime,
                     out_ch.voltage_sum, out_ch.voltage_diff, out_ch.saturated);
          end
        end else begin
          want = drive_fifo.pop_front();
          if (want.saturated) begin
            clipped_results++;
          end
          if (out_ch.voltage_sum !== want.voltage_sum ||
              out_ch.voltage_diff !== want.voltage_diff ||
              out_ch.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch expected sum=%h diff=%h sat=%b got sum=%h diff=%h sat=%b",
                       $realtime, want.voltage_sum, want.voltage_diff, want.saturated,
                       out_ch.voltage_sum, out_ch.voltage_diff, out_ch.saturated);
            end
          end
        end
      end
      // long hold-off on request, otherwise a rotating stall pattern
      cyc++;
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case ((cyc >> 6) % 4)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 9) >= 3);
          2:       out_ch.ready <= ((cyc % 5) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) >= 7);
        endcase
      end
    end
  end

  // ends the run when no channel moves a word for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, drive_fifo.size());
        $display("dual_pi_feedforward_speed_control_tb: errors");
        $finish;
      end
    end
  end

  // reset, then the tests in turn
  initial begin : stimulus
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.func          <= FUNC_STEP;
    in_ch.target_move   <= '0;
    in_ch.measured_move <= '0;
    in_ch.target_turn   <= '0;
    in_ch.measured_turn <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_MOVE_ACCEL;
    cfg_ch.data         <= '0;
    move_gain        = '0;
    turn_gain        = '0;
    move_integ       = 0;
    turn_integ       = 0;
    prev_target_move = 0;
    prev_target_turn = 0;
    held_sum         = 0;
    held_diff        = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_cases();
    test_stalled_result();
    test_random_trajectories();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d words: %0d steps, %0d clears, %0d decays, %0d unused codes",
             steps_sent + clears_sent + decays_sent + unused_sent, steps_sent, clears_sent,
             decays_sent, unused_sent);
    $display("%0d results checked, %0d clipped, %0d gain sets, %0d mismatches, %0d left",
             results_checked, clipped_results, gain_sets, mismatches, drive_fifo.size());
    if (mismatches == 0 && drive_fifo.size() == 0) begin
      $display("dual_pi_feedforward_speed_control_tb: clean");
    end else begin
      $display("dual_pi_feedforward_speed_control_tb: errors");
    end
    $finish;
  end

endmodule
